// ===== sv/pfap_pkg.sv =====
// ----------------------------------------------------------------------------
// pfap_pkg
// Shared types, codes and helpers for the pixel format to ARGB packer.
// ----------------------------------------------------------------------------
package pfap_pkg;

    // source layout codes
    localparam logic [2:0] LAYOUT_ALPHA = 3'd0;
    localparam logic [2:0] LAYOUT_LUM   = 3'd1;
    localparam logic [2:0] LAYOUT_LUMA  = 3'd2;
    localparam logic [2:0] LAYOUT_RGB   = 3'd3;
    localparam logic [2:0] LAYOUT_RGBA  = 3'd4;

    // configuration register indexes
    localparam int         CFG_IDX_W       = 3;
    localparam logic [2:0] CFG_SRC_LAYOUT  = 3'd0;
    localparam logic [2:0] CFG_IMG_WIDTH   = 3'd1;
    localparam logic [2:0] CFG_IMG_HEIGHT  = 3'd2;
    localparam logic [2:0] CFG_ROW_PITCH   = 3'd3;
    localparam logic [2:0] CFG_DEST_BASE   = 3'd4;

    localparam logic [7:0] FILL_BYTE = 8'hFF;

    // pixel queue depth
    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [12:0] width;
        logic [12:0] height;
        logic [14:0] pitch;
        logic [31:0] base;
    } t_geom;

    typedef struct packed {
        logic        push;
        logic [31:0] word;
    } t_q_wr;

    typedef struct packed {
        logic        valid;
        logic [31:0] word;
    } t_q_rd;

    // index of the byte that completes a pixel (bytes per pixel minus one)
    function automatic logic [1:0] last_phase(input logic [2:0] layout);
        logic [1:0] lp;
        unique case (layout)
            LAYOUT_ALPHA, LAYOUT_LUM: lp = 2'd0;
            LAYOUT_LUMA:              lp = 2'd1;
            LAYOUT_RGB:               lp = 2'd2;
            default:                  lp = 2'd3;
        endcase
        return lp;
    endfunction

    function automatic logic [31:0] pack_word(input logic [2:0]  layout,
                                              input logic [23:0] held,
                                              input logic [7:0]  cur);
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [31:0] w;
        b0 = held[7:0];
        b1 = held[15:8];
        b2 = held[23:16];
        unique case (layout)
            LAYOUT_ALPHA: w = {cur, FILL_BYTE, FILL_BYTE, FILL_BYTE};
            LAYOUT_LUM:   w = {FILL_BYTE, cur, cur, cur};
            LAYOUT_LUMA:  w = {cur, b0, b0, b0};
            LAYOUT_RGB:   w = {FILL_BYTE, b0, b1, cur};
            default:      w = {cur, b0, b1, b2};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/pfap_byte_if.sv =====
// ----------------------------------------------------------------------------
// pfap_byte_if
// Source byte channel: one texture byte per beat.
// ----------------------------------------------------------------------------
interface pfap_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_byte;

    modport source (output valid, output src_byte, input ready);
    modport sink   (input valid, input src_byte, output ready);
endinterface

// ===== sv/pfap_pix_if.sv =====
// ----------------------------------------------------------------------------
// pfap_pix_if
// Result channel: one ARGB8888 pixel with its destination offset per beat.
// ----------------------------------------------------------------------------
interface pfap_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] argb_word;
    logic [31:0] dest_offset;
    logic        last_pixel;

    modport source (output valid, output argb_word, output dest_offset,
                    output last_pixel, input ready);
    modport sink   (input valid, input argb_word, input dest_offset,
                    input last_pixel, output ready);
endinterface

// ===== sv/pfap_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pfap_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface pfap_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/pfap_front.sv =====
// ----------------------------------------------------------------------------
// pfap_front
// Gathers source bytes into pixels and pushes packed ARGB words.
// ----------------------------------------------------------------------------
module pfap_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_layout,
    pfap_byte_if.sink     i_src,
    input  logic          i_q_full,
    output pfap_pkg::t_q_wr o_q_wr
);
    import pfap_pkg::*;

    logic [1:0]  r_phase;
    logic [1:0]  n_phase;
    logic [23:0] r_gather;
    logic [23:0] n_gather;
    logic        complete;
    logic        accept;

    // byte closes the pixel once the gathered count reaches the layout's last phase
    assign complete      = (r_phase >= last_phase(i_layout));
    assign i_src.ready   = !complete || !i_q_full;
    assign accept        = i_src.valid && i_src.ready;

    assign o_q_wr.push = accept && complete;
    assign o_q_wr.word = pack_word(i_layout, r_gather, i_src.src_byte);

    always_comb begin
        n_phase  = r_phase;
        n_gather = r_gather;
        if (accept) begin
            if (complete) begin
                n_phase  = 2'd0;
                n_gather = 24'd0;
            end else begin
                n_phase = r_phase + 2'd1;
                case (r_phase)
                    2'd0:    n_gather[7:0]   = r_gather[7:0]   | i_src.src_byte;
                    2'd1:    n_gather[15:8]  = r_gather[15:8]  | i_src.src_byte;
                    default: n_gather[23:16] = r_gather[23:16] | i_src.src_byte;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 2'd0;
            r_gather <= 24'd0;
        end else begin
            r_phase  <= n_phase;
            r_gather <= n_gather;
        end
    end

`ifndef NO_ASSERTIONS
    a_phase_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !complete |=> r_phase == $past(r_phase) + 2'd1)
        else $error("byte phase did not advance on a gathered byte");
`endif

endmodule

// ===== sv/pfap_queue.sv =====
// ----------------------------------------------------------------------------
// pfap_queue
// Short pixel queue between the gather front and the address back.
// ----------------------------------------------------------------------------
module pfap_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfap_pkg::t_q_wr i_wr,
    output logic            o_full,
    output pfap_pkg::t_q_rd o_rd,
    input  logic            i_pop
);
    import pfap_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [31:0]      r_entry [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full     = (r_count == CNT_W'(Q_DEPTH));
    assign o_rd.valid = (r_count != '0);
    assign o_rd.word  = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_wr.push && !(i_pop && o_rd.valid)) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr.push && i_pop && o_rd.valid) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.push) begin
            r_entry[r_wr_ptr] <= i_wr.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_wr.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop && o_rd.valid) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr.push |-> !o_full)
        else $error("pixel pushed into a full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(Q_DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== sv/pfap_back.sv =====
// ----------------------------------------------------------------------------
// pfap_back
// Tracks column and row, forms destination offsets, holds the result beat.
// ----------------------------------------------------------------------------
module pfap_back #(
    parameter int MAX_DIM = 4096
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pfap_pkg::t_geom i_geom,
    input  pfap_pkg::t_q_rd i_q,
    output logic            o_pop,
    pfap_pix_if.source      o_pix
);
    import pfap_pkg::*;

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CMP_W = (CNT_W + 1 > 13) ? CNT_W + 1 : 13;

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_row;
    logic [31:0]      r_row_start;
    logic [31:0]      n_row_start;
    logic             r_valid;
    logic [31:0]      r_word;
    logic [31:0]      r_offset;
    logic             r_last;

    logic [CMP_W-1:0] w_c;
    logic [CMP_W-1:0] h_c;
    logic [31:0]      base_sel;
    logic [31:0]      offset;
    logic             row_end;
    logic             last;

    function automatic logic [CMP_W-1:0] clamp_dim(input logic [12:0] d);
        logic [CMP_W-1:0] x;
        x = CMP_W'(d);
        if (x == '0) begin
            x = CMP_W'(1);
        end else if (x > CMP_W'(MAX_DIM)) begin
            x = CMP_W'(MAX_DIM);
        end
        return x;
    endfunction

    assign w_c   = clamp_dim(i_geom.width);
    assign h_c   = clamp_dim(i_geom.height);
    assign o_pop = i_q.valid && (!r_valid || o_pix.ready);

    always_comb begin
        base_sel = ((r_col == '0) && (r_row == '0)) ? i_geom.base : r_row_start;
        offset   = base_sel + (32'(r_col) << 2);
        row_end  = (CMP_W'(r_col) + CMP_W'(1)) >= w_c;
        last     = row_end && ((CMP_W'(r_row) + CMP_W'(1)) >= h_c);

        n_col       = r_col;
        n_row       = r_row;
        n_row_start = r_row_start;
        if (o_pop) begin
            n_row_start = base_sel;
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (row_end) begin
                n_col       = '0;
                n_row       = r_row + CNT_W'(1);
                n_row_start = base_sel + 32'(i_geom.pitch);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_row_start <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_row_start <= n_row_start;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word   <= i_q.word;
            r_offset <= offset;
            r_last   <= last;
        end
    end

    assign o_pix.valid       = r_valid;
    assign o_pix.argb_word   = r_word;
    assign o_pix.dest_offset = r_offset;
    assign o_pix.last_pixel  = r_last;

`ifndef NO_ASSERTIONS
    a_rearm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop && last |=> (r_col == '0) && (r_row == '0) && r_valid && r_last)
        else $error("counters did not rearm after the last pixel");
`endif

endmodule

// ===== sv/pixel_format_to_argb_packer_core.sv =====
// ----------------------------------------------------------------------------
// pixel_format_to_argb_packer_core
// Packs a byte stream of A, L, LA, RGB or RGBA texels into ARGB8888 words
// with destination byte offsets.
// ----------------------------------------------------------------------------
//
//  channel   dir  beat carries                              handshake
//  --------  ---  ----------------------------------------  -----------
//  i_src     in   src_byte[7:0]                             valid/ready
//  o_pix     out  argb_word[31:0] dest_offset[31:0] last    valid/ready
//  i_cfg     in   index[2:0] data[31:0]                     valid/ready
//
//  One source byte per cycle is taken unless the queue is full; a pixel goes
//  from the front gather through the queue to the output register in the back.
//  i_rst_n is synchronous: counters, phase and queue clear, registers load
//  their defaults (RGBA, 1x1, pitch 4, base 0).
//  A stalled o_pix fills the two-entry queue; i_src then stalls only on
//  bytes that close a pixel. Config is always ready.
//
module pixel_format_to_argb_packer_core #(
    parameter int MAX_DIM = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfap_byte_if.sink  i_src,
    pfap_pix_if.source o_pix,
    pfap_cfg_if.sink   i_cfg
);
    import pfap_pkg::*;

    // configuration registers
    logic [2:0]  r_source_layout;
    logic [12:0] r_image_width;
    logic [12:0] r_image_height;
    logic [14:0] r_row_pitch;
    logic [31:0] r_dest_base;

    t_geom geom;
    t_q_wr q_wr;
    t_q_rd q_rd;
    logic  q_full;
    logic  q_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_layout <= LAYOUT_RGBA;
            r_image_width   <= 13'd1;
            r_image_height  <= 13'd1;
            r_row_pitch     <= 15'd4;
            r_dest_base     <= 32'd0;
        end else if (i_cfg.valid) begin
            // unknown indexes fall through untouched
            case (i_cfg.index)
                CFG_SRC_LAYOUT: r_source_layout <= i_cfg.data[2:0];
                CFG_IMG_WIDTH:  r_image_width   <= i_cfg.data[12:0];
                CFG_IMG_HEIGHT: r_image_height  <= i_cfg.data[12:0];
                CFG_ROW_PITCH:  r_row_pitch     <= i_cfg.data[14:0];
                CFG_DEST_BASE:  r_dest_base     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign geom.width  = r_image_width;
    assign geom.height = r_image_height;
    assign geom.pitch  = r_row_pitch;
    assign geom.base   = r_dest_base;

    // front: byte gather and channel fill
    pfap_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_layout (r_source_layout),
        .i_src    (i_src),
        .i_q_full (q_full),
        .o_q_wr   (q_wr)
    );

    // decouples gather from the output stall
    pfap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .o_full  (q_full),
        .o_rd    (q_rd),
        .i_pop   (q_pop)
    );

    // back: position counters, offset, result register
    pfap_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_geom  (geom),
        .i_q     (q_rd),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ARGB8888 pixel packer. Source bytes go in under
// random gaps and stalls, and a local model of the packer predicts each
// pixel's word, destination offset and last flag, which are checked in order.
// ----------------------------------------------------------------------------
module testbench;
    import pfap_pkg::*;

    localparam int MAX_DIM        = 4096;
    localparam int CYCLE_LIMIT    = 300000;
    // drain margin: a pixel passes the queue and output register after its closing byte
    localparam int DRAIN_CYCLES   = 8;
    localparam int RX_HOLD_CYCLES = 200;

    // layout codes without a name in the package: the packer treats them as RGBA
    localparam logic [2:0] LAYOUT_SPARE_5 = 3'd5;
    localparam logic [2:0] LAYOUT_SPARE_6 = 3'd6;
    localparam logic [2:0] LAYOUT_SPARE_7 = 3'd7;
    // register indexes beyond the map: writes are dropped
    localparam logic [2:0] CFG_SPARE_5    = 3'd5;
    localparam logic [2:0] CFG_SPARE_6    = 3'd6;
    localparam logic [2:0] CFG_SPARE_7    = 3'd7;

    typedef struct packed {
        logic [31:0] argb;
        logic [31:0] offset;
        logic        last;
    } pixel_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    pfap_byte_if src_bus ();
    pfap_pix_if  pix_bus ();
    pfap_cfg_if  cfg_bus ();

    pixel_format_to_argb_packer_core #(
        .MAX_DIM (MAX_DIM)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_src   (src_bus),
        .o_pix   (pix_bus),
        .i_cfg   (cfg_bus)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Packer model: register copies and gather / position state
    // ------------------------------------------------------------------------
    logic [2:0]  cfg_layout;
    logic [12:0] cfg_width;
    logic [12:0] cfg_height;
    logic [14:0] cfg_pitch;
    logic [31:0] cfg_base;

    logic [1:0]  gather_phase;
    logic [23:0] gather_bytes;
    logic [12:0] col_pos;
    logic [12:0] row_pos;
    logic [31:0] row_base;

    pixel_t expected_pixels [$];

    int   mismatches    = 0;
    int   cycle_count   = 0;
    int   src_idle_pct  = 0;
    int   pix_stall_pct = 0;
    logic rx_hold       = 1'b0;
    event hold_off_ev;

    function automatic int bytes_per_texel(input logic [2:0] layout);
        case (layout)
            LAYOUT_ALPHA, LAYOUT_LUM: return 1;
            LAYOUT_LUMA:              return 2;
            LAYOUT_RGB:               return 3;
            default:                  return 4;
        endcase
    endfunction

    // zero reads as one, anything past MAX_DIM saturates
    function automatic int clamp_dim(input logic [12:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // advance the model by one accepted source beat
    task automatic predict_byte(input logic [7:0] b);
        int         need;
        int         w;
        int         h;
        logic [7:0] a;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] bl;
        logic       row_end;
        pixel_t     px;
        need = bytes_per_texel(cfg_layout);
        if (int'(gather_phase) + 1 < need) begin
            // still gathering: byte k sits in bits 8k+7..8k
            gather_bytes = gather_bytes | (24'(b) << (8 * gather_phase));
            gather_phase = gather_phase + 2'd1;
        end else begin
            // closing byte; earlier bytes keep their slots even after a
            // layout change part way through the pixel
            case (cfg_layout)
                LAYOUT_ALPHA: begin
                    a = b;    r = 8'hFF;  g = 8'hFF;  bl = 8'hFF;
                end
                LAYOUT_LUM: begin
                    a = 8'hFF; r = b;     g = b;      bl = b;
                end
                LAYOUT_LUMA: begin
                    a = b;
                    r = gather_bytes[7:0];
                    g = gather_bytes[7:0];
                    bl = gather_bytes[7:0];
                end
                LAYOUT_RGB: begin
                    a = 8'hFF;
                    r = gather_bytes[7:0];
                    g = gather_bytes[15:8];
                    bl = b;
                end
                default: begin
                    a = b;
                    r = gather_bytes[7:0];
                    g = gather_bytes[15:8];
                    bl = gather_bytes[23:16];
                end
            endcase
            gather_phase = '0;
            gather_bytes = '0;

            w = clamp_dim(cfg_width);
            h = clamp_dim(cfg_height);
            // base is only picked up at the first pixel of an image
            if (col_pos == 0 && row_pos == 0)
                row_base = cfg_base;
            px.argb   = {a, r, g, bl};
            px.offset = row_base + {col_pos, 2'b00};
            row_end   = (int'(col_pos) + 1 >= w);
            px.last   = row_end && (int'(row_pos) + 1 >= h);

            if (px.last) begin
                col_pos = '0;
                row_pos = '0;
            end else if (row_end) begin
                col_pos  = '0;
                row_pos  = row_pos + 13'd1;
                row_base = row_base + 32'(cfg_pitch);
            end else begin
                col_pos = col_pos + 13'd1;
            end
            expected_pixels.push_back(px);
        end
    endtask

    // follow every accepted config and source beat
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_layout   = LAYOUT_RGBA;
            cfg_width    = 13'd1;
            cfg_height   = 13'd1;
            cfg_pitch    = 15'd4;
            cfg_base     = '0;
            gather_phase = '0;
            gather_bytes = '0;
            col_pos      = '0;
            row_pos      = '0;
            row_base     = '0;
        end else begin
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    CFG_SRC_LAYOUT: cfg_layout = cfg_bus.data[2:0];
                    CFG_IMG_WIDTH:  cfg_width  = cfg_bus.data[12:0];
                    CFG_IMG_HEIGHT: cfg_height = cfg_bus.data[12:0];
                    CFG_ROW_PITCH:  cfg_pitch  = cfg_bus.data[14:0];
                    CFG_DEST_BASE:  cfg_base   = cfg_bus.data;
                    default: ;
                endcase
            end
            if (src_bus.valid && src_bus.ready)
                predict_byte(src_bus.src_byte);
        end
    end

    // compare each pixel beat with the oldest prediction
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %h @ %h with none pending",
                                          pix_bus.argb_word, pix_bus.dest_offset));
            end else begin
                want = expected_pixels.pop_front();
                if (pix_bus.argb_word !== want.argb)
                    report_mismatch($sformatf("argb_word got %h want %h",
                                              pix_bus.argb_word, want.argb));
                if (pix_bus.dest_offset !== want.offset)
                    report_mismatch($sformatf("dest_offset got %h want %h",
                                              pix_bus.dest_offset, want.offset));
                if (pix_bus.last_pixel !== want.last)
                    report_mismatch($sformatf("last_pixel got %b want %b",
                                              pix_bus.last_pixel, want.last));
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk)
        pix_bus.ready <= !rx_hold && ($urandom_range(99) >= pix_stall_pct);

    always begin
        @(hold_off_ev);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t ERROR timeout, %0d pixels outstanding",
                     $time, expected_pixels.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // one source beat; valid is left high so back-to-back beats need no gap
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            src_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_bus.valid    <= 1'b1;
        src_bus.src_byte <= b;
        @(posedge i_clk);
        while (!src_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic send_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(255)));
    endtask

    // one config beat; caller drops valid once its writes are done
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        @(posedge i_clk);
        while (!cfg_bus.ready)
            @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
        write_reg(idx, val);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic configure(input logic [2:0]  layout,
                             input logic [12:0] width,
                             input logic [12:0] height,
                             input logic [14:0] pitch,
                             input logic [31:0] base);
        write_reg(CFG_SRC_LAYOUT, 32'(layout));
        write_reg(CFG_IMG_WIDTH,  32'(width));
        write_reg(CFG_IMG_HEIGHT, 32'(height));
        write_reg(CFG_ROW_PITCH,  32'(pitch));
        write_reg(CFG_DEST_BASE,  base);
        cfg_bus.valid <= 1'b0;
    endtask

    // all pixels out, then let any byte still in the gather stage settle
    task automatic wait_idle();
        src_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset defaults, then one 1x1 image per layout code with extreme bytes
    task automatic test_layouts_directed();
        logic [2:0] codes [8];
        codes = '{LAYOUT_ALPHA, LAYOUT_LUM, LAYOUT_LUMA, LAYOUT_RGB, LAYOUT_RGBA,
                  LAYOUT_SPARE_5, LAYOUT_SPARE_6, LAYOUT_SPARE_7};
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        foreach (codes[k]) begin
            wait_idle();
            configure(codes[k], 13'd1, 13'd1, 15'd4, 32'h0);
            for (int j = 0; j < bytes_per_texel(codes[k]); j++)
                send_byte(((j + k) % 2) ? 8'hFF : 8'h00);
        end
        wait_idle();
    endtask

    // degenerate geometry and registers changed part way through
    task automatic test_open_cases();
        // zero dimensions read as one: every byte closes an image
        configure(LAYOUT_LUM, 13'd0, 13'd0, 15'd0, 32'hFFFF_FFFC);
        send_random_bytes(3);
        wait_idle();

        // pitch narrower than a row, base near the top: overlap and wrap
        configure(LAYOUT_LUMA, 13'd3, 13'd2, 15'd4, 32'hFFFF_FFF8);
        send_random_bytes(12);
        wait_idle();

        configure(LAYOUT_RGB, 13'd2, 13'd3, 15'h7FFF, 32'hFFFF_0000);
        send_random_bytes(18);
        wait_idle();

        // layout switched with two RGBA bytes held: next byte closes as LA
        configure(LAYOUT_RGBA, 13'd4, 13'd2, 15'd16, 32'h0000_1000);
        send_random_bytes(2);
        wait_idle();
        set_reg(CFG_SRC_LAYOUT, 32'(LAYOUT_LUMA));
        send_random_bytes(1);
        // one LA byte held, then alpha-only closes on the next
        send_random_bytes(1);
        wait_idle();
        set_reg(CFG_SRC_LAYOUT, 32'(LAYOUT_ALPHA));
        send_random_bytes(1);
        wait_idle();

        // new base mid-image waits for the next image
        set_reg(CFG_DEST_BASE, 32'h8000_0000);
        send_random_bytes(1);
        wait_idle();
        // width shrunk below the column: row ends at once
        set_reg(CFG_IMG_WIDTH, 32'd1);
        send_random_bytes(1);
        wait_idle();
        // height shrunk below the row: image ends
        set_reg(CFG_IMG_HEIGHT, 32'd1);
        send_random_bytes(3);
        wait_idle();

        // writes beyond the register map change nothing
        set_reg(CFG_SPARE_5, $urandom);
        set_reg(CFG_SPARE_6, $urandom);
        set_reg(CFG_SPARE_7, $urandom);
        send_random_bytes(2);
        wait_idle();
    endtask

    // receiver holds off while bytes keep coming: queue fills, input stalls
    task automatic test_back_pressure();
        int saved_idle;
        saved_idle   = src_idle_pct;
        src_idle_pct = 0;
        configure(LAYOUT_RGBA, 13'd4, 13'd3, 15'd16, $urandom);
        -> hold_off_ev;
        send_random_bytes(48);
        src_idle_pct = saved_idle;
        wait_idle();
    endtask

    // width, then height, just past MAX_DIM: must saturate, not wrap to one
    task automatic test_dimension_limits();
        configure(LAYOUT_ALPHA, 13'd4097, 13'd1, 15'h7FFF, $urandom);
        send_random_bytes(32);
        wait_idle();
        configure(LAYOUT_LUM, 13'd1, 13'd4097, 15'd16384, $urandom);
        send_random_bytes(32);
        wait_idle();
    endtask

    // mostly whole images of random geometry; some truncated or overrun
    task automatic test_random_images(input int n_bytes);
        int          sent;
        int          pick;
        int          w;
        int          h;
        int          wreg;
        int          hreg;
        int          pitch;
        int          count;
        logic [2:0]  layout;
        sent = 0;
        while (sent < n_bytes) begin
            pick   = $urandom_range(99);
            layout = (pick < 10) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(4));
            if (pick >= 10 && pick < 15) begin
                w = $urandom_range(9, 40);
                h = 1;
            end else begin
                w = $urandom_range(1, 8);
                h = $urandom_range(1, 5);
            end
            wreg = w;
            hreg = h;
            if (pick >= 15 && pick < 18) begin
                wreg = 0;
                w    = 1;
            end
            if (pick >= 18 && pick < 21) begin
                hreg = 0;
                h    = 1;
            end
            case ($urandom_range(3))
                0:       pitch = w * 4;
                1:       pitch = w * 4 + $urandom_range(1, 256);
                2:       pitch = $urandom_range(w * 4);
                default: pitch = $urandom_range(32767);
            endcase

            wait_idle();
            configure(layout, 13'(wreg), 13'(hreg), 15'(pitch), $urandom);
            if (pick >= 21 && pick < 24)
                set_reg(CFG_SPARE_5 + 3'($urandom_range(2)), $urandom);

            count = w * h * bytes_per_texel(layout);
            // broken stream: stop short or spill into the next image
            if (pick >= 88)
                count = $urandom_range(count + 7);
            send_random_bytes(count);
            sent += count;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        src_bus.valid    = 1'b0;
        src_bus.src_byte = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver stalls often
        src_idle_pct  = 23;
        pix_stall_pct = 72;
        test_layouts_directed();
        test_open_cases();
        test_random_images(100);

        // sender sparse, receiver mostly ready
        src_idle_pct  = 72;
        pix_stall_pct = 23;
        test_back_pressure();
        test_random_images(100);

        // full rate both ways
        src_idle_pct  = 0;
        pix_stall_pct = 0;
        test_dimension_limits();
        test_random_images(100);

        wait_idle();
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
